FILE: hdl/pidsl_pkg.sv
// Package for the position PID core with slew-limited velocity output.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies.
package pidsl_pkg;

    localparam int GAIN_FRAC_DEF  = 16;
    localparam int INTEGRAL_W_DEF = 32;

    localparam int POS_W      = 24;
    localparam int ERR_W      = 25;
    localparam int DER_W      = 26;
    localparam int GAIN_W     = 24;
    localparam int WIN_W      = 23;
    localparam int VEL_LIM_W  = 10;
    localparam int TOL_W      = 16;
    localparam int STEP_W     = 10;
    localparam int VEL_W      = 11;
    localparam int SLEW_W     = VEL_W + 2;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam int P_W           = GAIN_W + 1 + ERR_W;
    localparam int D_W           = GAIN_W + 1 + DER_W;
    localparam int PD_W          = D_W + 1;
    localparam int TERM_SAT_LOG2 = 60;
    localparam int ITERM_W       = TERM_SAT_LOG2 + 2;
    localparam int TOT_W         = ITERM_W + 1;

    localparam int STAGES = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP = 3'd7;

    localparam logic [POS_W-1:0]     RST_GOAL      = 24'd0;
    localparam logic [GAIN_W-1:0]    RST_GAIN_P    = 24'd49152;
    localparam logic [GAIN_W-1:0]    RST_GAIN_I    = 24'd33;
    localparam logic [GAIN_W-1:0]    RST_GAIN_D    = 24'd66;
    localparam logic [WIN_W-1:0]     RST_WINDOW    = 23'd300;
    localparam logic [VEL_LIM_W-1:0] RST_VEL_LIMIT = 10'd70;
    localparam logic [TOL_W-1:0]     RST_TOLERANCE = 16'd4;
    localparam logic [STEP_W-1:0]    RST_SLEW_STEP = 10'd10;

    typedef struct packed {
        logic [POS_W-1:0]     goal_position;
        logic [GAIN_W-1:0]    gain_p;
        logic [GAIN_W-1:0]    gain_i;
        logic [GAIN_W-1:0]    gain_d;
        logic [WIN_W-1:0]     integral_window;
        logic [VEL_LIM_W-1:0] velocity_limit;
        logic [TOL_W-1:0]     done_tolerance;
        logic [STEP_W-1:0]    slew_step;
    } t_cfg;

    typedef struct packed {
        logic ld_out;
        logic ld_tgt;
        logic ld_sum;
        logic ld_mul;
        logic ld_err;
        logic ld_in;
    } t_load;

endpackage

FILE: hdl/pidsl_err.sv
// Input register and error stage: error, windowed saturating integral, derivative.
// Owns the integral and previous-error state. Depends on pidsl_pkg.
module pidsl_err
    import pidsl_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = INTEGRAL_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_load                            i_load,
    input  t_cfg                             i_cfg,
    input  logic [POS_W-1:0]                 i_encoder_position,
    input  logic                             i_start_move,
    output logic signed [ERR_W-1:0]          o_err,
    output logic signed [DER_W-1:0]          o_deriv,
    output logic signed [INTEGRAL_WIDTH-1:0] o_integral,
    output logic                             o_goal_met
);

    localparam int SUM_W = INTEGRAL_WIDTH + 2;
    localparam logic signed [SUM_W-1:0] IMAX =
        {{(SUM_W-INTEGRAL_WIDTH+1){1'b0}}, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] IMIN =
        {{(SUM_W-INTEGRAL_WIDTH+1){1'b1}}, {(INTEGRAL_WIDTH-1){1'b0}}};

    logic [POS_W-1:0]                 r_pos;
    logic                             r_start;
    logic signed [INTEGRAL_WIDTH-1:0] r_integral;
    logic signed [ERR_W-1:0]          r_last_err;
    logic signed [DER_W-1:0]          r_deriv;
    logic                             r_met;

    logic signed [ERR_W-1:0]          w_goal;
    logic signed [ERR_W-1:0]          w_err;
    logic [ERR_W-1:0]                 w_emag;
    logic signed [INTEGRAL_WIDTH-1:0] w_base_int;
    logic signed [ERR_W-1:0]          w_base_last;
    logic signed [SUM_W-1:0]          w_sum;
    logic signed [SUM_W-1:0]          w_sat;
    logic signed [INTEGRAL_WIDTH-1:0] n_integral;
    logic signed [DER_W-1:0]          n_deriv;
    logic                             n_met;

    always_comb begin
        w_goal = $signed({i_cfg.goal_position[POS_W-1], i_cfg.goal_position});
        w_err  = w_goal - $signed({r_pos[POS_W-1], r_pos});
        w_emag = w_err[ERR_W-1] ? $unsigned(-w_err) : $unsigned(w_err);

        // start of a move: clear the integral, seed previous error with the goal
        w_base_int  = r_start ? '0 : r_integral;
        w_base_last = r_start ? w_goal : r_last_err;

        w_sum = $signed({{(SUM_W-INTEGRAL_WIDTH){w_base_int[INTEGRAL_WIDTH-1]}}, w_base_int})
              + $signed({{(SUM_W-ERR_W){w_err[ERR_W-1]}}, w_err});
        if (w_sum > IMAX) begin
            w_sat = IMAX;
        end else if (w_sum < IMIN) begin
            w_sat = IMIN;
        end else begin
            w_sat = w_sum;
        end

        if (w_emag < ERR_W'(i_cfg.integral_window)) begin
            n_integral = w_sat[INTEGRAL_WIDTH-1:0];
        end else begin
            n_integral = w_base_int;
        end

        n_deriv = $signed({w_err[ERR_W-1], w_err})
                - $signed({w_base_last[ERR_W-1], w_base_last});
        n_met   = w_emag < ERR_W'(i_cfg.done_tolerance);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
            r_last_err <= '0;
        end else if (i_load.ld_err) begin
            r_integral <= n_integral;
            r_last_err <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.ld_in) begin
            r_pos   <= i_encoder_position;
            r_start <= i_start_move;
        end
        if (i_load.ld_err) begin
            r_deriv <= n_deriv;
            r_met   <= n_met;
        end
    end

    assign o_err      = r_last_err;
    assign o_deriv    = r_deriv;
    assign o_integral = r_integral;
    assign o_goal_met = r_met;

endmodule

FILE: hdl/pidsl_mul.sv
// Gain stages: P, D and split I products, then saturated I term and P+D sum.
// Depends on pidsl_pkg.
module pidsl_mul
    import pidsl_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = INTEGRAL_W_DEF
) (
    input  logic                             i_clk,
    input  t_load                            i_load,
    input  t_cfg                             i_cfg,
    input  logic signed [ERR_W-1:0]          i_err,
    input  logic signed [DER_W-1:0]          i_deriv,
    input  logic signed [INTEGRAL_WIDTH-1:0] i_integral,
    input  logic                             i_goal_met,
    output logic signed [ITERM_W-1:0]        o_iterm,
    output logic signed [PD_W-1:0]           o_pd,
    output logic                             o_goal_met
);

    localparam int LO_W  = INTEGRAL_WIDTH / 2;
    localparam int HI_W  = INTEGRAL_WIDTH - LO_W;
    localparam int IP_W  = GAIN_W + INTEGRAL_WIDTH;
    localparam int SAT_W = (IP_W > TERM_SAT_LOG2 + 1) ? IP_W : TERM_SAT_LOG2 + 1;
    localparam logic [SAT_W-1:0] TERM_SAT = SAT_W'(1) << TERM_SAT_LOG2;

    logic signed [P_W-1:0]     r_pterm;
    logic signed [D_W-1:0]     r_dterm;
    logic [GAIN_W+LO_W-1:0]    r_plo;
    logic [GAIN_W+HI_W-1:0]    r_phi;
    logic                      r_ineg;
    logic                      r_met2;
    logic signed [ITERM_W-1:0] r_iterm;
    logic signed [PD_W-1:0]    r_pd;
    logic                      r_met3;

    logic [INTEGRAL_WIDTH-1:0] w_imag;
    logic signed [P_W-1:0]     n_pterm;
    logic signed [D_W-1:0]     n_dterm;
    logic [GAIN_W+LO_W-1:0]    n_plo;
    logic [GAIN_W+HI_W-1:0]    n_phi;
    logic [IP_W-1:0]           w_imul;
    logic [SAT_W-1:0]          w_iext;
    logic [SAT_W-1:0]          w_isat;
    logic signed [ITERM_W-1:0] w_ipos;
    logic signed [ITERM_W-1:0] n_iterm;
    logic signed [PD_W-1:0]    n_pd;

    always_comb begin
        w_imag  = i_integral[INTEGRAL_WIDTH-1] ? $unsigned(-i_integral)
                                               : $unsigned(i_integral);
        n_pterm = $signed({1'b0, i_cfg.gain_p}) * i_err;
        n_dterm = $signed({1'b0, i_cfg.gain_d}) * i_deriv;
        n_plo   = (GAIN_W+LO_W)'(i_cfg.gain_i) * (GAIN_W+LO_W)'(w_imag[LO_W-1:0]);
        n_phi   = (GAIN_W+HI_W)'(i_cfg.gain_i)
                * (GAIN_W+HI_W)'(w_imag[INTEGRAL_WIDTH-1:LO_W]);
    end

    always_comb begin
        w_imul  = (IP_W'(r_phi) << LO_W) + IP_W'(r_plo);
        w_iext  = SAT_W'(w_imul);
        w_isat  = (w_iext > TERM_SAT) ? TERM_SAT : w_iext;
        w_ipos  = $signed({1'b0, w_isat[TERM_SAT_LOG2:0]});
        n_iterm = r_ineg ? -w_ipos : w_ipos;
        n_pd    = $signed({{(PD_W-P_W){r_pterm[P_W-1]}}, r_pterm})
                + $signed({{(PD_W-D_W){r_dterm[D_W-1]}}, r_dterm});
    end

    always_ff @(posedge i_clk) begin
        if (i_load.ld_mul) begin
            r_pterm <= n_pterm;
            r_dterm <= n_dterm;
            r_plo   <= n_plo;
            r_phi   <= n_phi;
            r_ineg  <= i_integral[INTEGRAL_WIDTH-1];
            r_met2  <= i_goal_met;
        end
        if (i_load.ld_sum) begin
            r_iterm <= n_iterm;
            r_pd    <= n_pd;
            r_met3  <= r_met2;
        end
    end

    assign o_iterm    = r_iterm;
    assign o_pd       = r_pd;
    assign o_goal_met = r_met3;

endmodule

FILE: hdl/pidsl_out.sv
// Output stages: truncate and clamp the loop sum to the velocity target,
// then step the commanded velocity toward it, or to zero when the target is zero. Depends on pidsl_pkg.
module pidsl_out
    import pidsl_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_load                     i_load,
    input  t_cfg                      i_cfg,
    input  logic signed [ITERM_W-1:0] i_iterm,
    input  logic signed [PD_W-1:0]    i_pd,
    input  logic                      i_goal_met,
    output logic [VEL_W-1:0]          o_velocity_command,
    output logic                      o_goal_met
);

    logic signed [VEL_W-1:0]  r_target;
    logic                     r_met4;
    logic signed [VEL_W-1:0]  r_cv;
    logic                     r_met5;

    logic signed [TOT_W-1:0]  w_total;
    logic [TOT_W-1:0]         w_tmag;
    logic [TOT_W-1:0]         w_q;
    logic [VEL_LIM_W-1:0]     w_qlim;
    logic signed [VEL_W-1:0]  w_qpos;
    logic signed [VEL_W-1:0]  n_target;
    logic signed [SLEW_W-1:0] w_cv;
    logic signed [SLEW_W-1:0] w_tg;
    logic signed [SLEW_W-1:0] w_step;
    logic signed [SLEW_W-1:0] w_up;
    logic signed [SLEW_W-1:0] w_dn;
    logic signed [SLEW_W-1:0] w_next;

    always_comb begin
        w_total = $signed({{(TOT_W-ITERM_W){i_iterm[ITERM_W-1]}}, i_iterm})
                + $signed({{(TOT_W-PD_W){i_pd[PD_W-1]}}, i_pd});
        w_tmag  = w_total[TOT_W-1] ? $unsigned(-w_total) : $unsigned(w_total);
        w_q     = w_tmag >> GAIN_FRACTION_BITS;
        w_qlim  = (w_q > TOT_W'(i_cfg.velocity_limit)) ? i_cfg.velocity_limit
                                                       : w_q[VEL_LIM_W-1:0];
        w_qpos  = $signed({1'b0, w_qlim});
        n_target = w_total[TOT_W-1] ? -w_qpos : w_qpos;
    end

    always_comb begin
        w_cv   = SLEW_W'(r_cv);
        w_tg   = SLEW_W'(r_target);
        w_step = $signed(SLEW_W'(i_cfg.slew_step));
        w_up   = w_cv + w_step;
        w_dn   = w_cv - w_step;
        if (r_target == '0) begin
            w_next = '0;
        end else if (w_cv < w_tg) begin
            w_next = (w_up > w_tg) ? w_tg : w_up;
        end else if (w_cv > w_tg) begin
            w_next = (w_dn < w_tg) ? w_tg : w_dn;
        end else begin
            w_next = w_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else if (i_load.ld_out) begin
            r_cv <= w_next[VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.ld_tgt) begin
            r_target <= n_target;
            r_met4   <= i_goal_met;
        end
        if (i_load.ld_out) begin
            r_met5 <= r_met4;
        end
    end

    assign o_velocity_command = r_cv;
    assign o_goal_met         = r_met5;

endmodule

FILE: hdl/pid_position_with_slew_limit_core.sv
// Position PID core with slew-limited velocity command; top level.
// Six register stages (input, error, multiply, sum, target, output); an input transfer
// loads the first, and each result moves through them in order and out from the last.
// Throughput: one item per cycle unless the output stalls; stages advance where free.
// Reset (synchronous, active low): config registers take their defaults, integral,
// previous error and velocity clear to zero, pipeline empties.
// Depends on pidsl_pkg, pidsl_err, pidsl_mul, pidsl_out.
module pid_position_with_slew_limit_core
    import pidsl_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = GAIN_FRAC_DEF,
    parameter int INTEGRAL_WIDTH     = INTEGRAL_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [POS_W-1:0]      i_encoder_position,
    input  logic                  i_start_move,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [VEL_W-1:0]      o_velocity_command,
    output logic                  o_goal_met,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg               r_cfg;
    logic [STAGES-1:0]  r_vld;
    logic [STAGES-1:0]  w_rdy;
    logic [STAGES-1:0]  w_up;
    logic [STAGES-1:0]  w_load;
    t_load              w_ld;

    logic signed [ERR_W-1:0]          w_err;
    logic signed [DER_W-1:0]          w_deriv;
    logic signed [INTEGRAL_WIDTH-1:0] w_integral;
    logic                             w_met1;
    logic signed [ITERM_W-1:0]        w_iterm;
    logic signed [PD_W-1:0]           w_pd;
    logic                             w_met3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_position   <= RST_GOAL;
            r_cfg.gain_p          <= RST_GAIN_P;
            r_cfg.gain_i          <= RST_GAIN_I;
            r_cfg.gain_d          <= RST_GAIN_D;
            r_cfg.integral_window <= RST_WINDOW;
            r_cfg.velocity_limit  <= RST_VEL_LIMIT;
            r_cfg.done_tolerance  <= RST_TOLERANCE;
            r_cfg.slew_step       <= RST_SLEW_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GOAL:      r_cfg.goal_position   <= i_cfg_data[POS_W-1:0];
                CFG_GAIN_P:    r_cfg.gain_p          <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:    r_cfg.gain_i          <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:    r_cfg.gain_d          <= i_cfg_data[GAIN_W-1:0];
                CFG_WINDOW:    r_cfg.integral_window <= i_cfg_data[WIN_W-1:0];
                CFG_VEL_LIMIT: r_cfg.velocity_limit  <= i_cfg_data[VEL_LIM_W-1:0];
                CFG_TOLERANCE: r_cfg.done_tolerance  <= i_cfg_data[TOL_W-1:0];
                CFG_SLEW_STEP: r_cfg.slew_step       <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // stage k takes a transfer when it is empty or its item moves on
    always_comb begin
        w_rdy[STAGES-1] = !r_vld[STAGES-1] || !i_out_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_up   = {r_vld[STAGES-2:0], i_in_valid};
        w_load = w_up & w_rdy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (w_rdy & w_up) | (~w_rdy & r_vld);
        end
    end

    assign w_ld        = t_load'(w_load);
    assign o_in_stall  = !w_rdy[0];
    assign o_out_valid = r_vld[STAGES-1];

    pidsl_err #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_err (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (w_ld),
        .i_cfg              (r_cfg),
        .i_encoder_position (i_encoder_position),
        .i_start_move       (i_start_move),
        .o_err              (w_err),
        .o_deriv            (w_deriv),
        .o_integral         (w_integral),
        .o_goal_met         (w_met1)
    );

    pidsl_mul #(
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_mul (
        .i_clk      (i_clk),
        .i_load     (w_ld),
        .i_cfg      (r_cfg),
        .i_err      (w_err),
        .i_deriv    (w_deriv),
        .i_integral (w_integral),
        .i_goal_met (w_met1),
        .o_iterm    (w_iterm),
        .o_pd       (w_pd),
        .o_goal_met (w_met3)
    );

    pidsl_out #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_out (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (w_ld),
        .i_cfg              (r_cfg),
        .i_iterm            (w_iterm),
        .i_pd               (w_pd),
        .i_goal_met         (w_met3),
        .o_velocity_command (o_velocity_command),
        .o_goal_met         (o_goal_met)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled while a pipeline stage is empty");

    a_zero_tol_never_met: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cfg.done_tolerance == '0) |-> !o_goal_met)
        else $error("goal met reported with zero tolerance");

    a_zero_limit_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cfg.velocity_limit == '0) |-> (o_velocity_command == '0))
        else $error("nonzero velocity with zero velocity limit");

endmodule
